[design/ryb_pkg.sv]
`timescale 1ns / 1ps

package ryb_pkg;

   localparam int WORD_W = 32;
   localparam int TICK_W = 8;
   localparam logic [TICK_W-1:0] TICK_MAX = 8'd255;
   localparam logic [TICK_W-1:0] TICK_ONE = 8'd1;

   typedef enum logic [1:0] {
      FUNC_RECORD  = 2'd0,
      FUNC_REQUEST = 2'd1,
      FUNC_TICK    = 2'd2,
      FUNC_FLUSH   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      KIND_FLUSHED = 2'd0,
      KIND_GRANT   = 2'd1,
      KIND_MISS    = 2'd2,
      KIND_TICK    = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_APPEND,
      ST_FL_RD,
      ST_FL_OUT,
      ST_SR_RD,
      ST_SR_CHK,
      ST_TAIL_RD,
      ST_TAIL_WR,
      ST_EMIT
   } state_type;

   typedef struct packed {
      func_type            func;
      logic [WORD_W-1:0]   node_id;
      logic [WORD_W-1:0]   port_uid;
      logic [WORD_W-1:0]   send_count;
      logic [WORD_W-1:0]   send_once_count;
   } req_word_type;

   typedef struct packed {
      kind_type            result_kind;
      logic [WORD_W-1:0]   dest_node_out;
      logic [WORD_W-1:0]   uid_out;
      logic [WORD_W-1:0]   send_count_out;
      logic [WORD_W-1:0]   send_once_out;
      logic                timeout_fire;
      logic                last;
   } rsp_word_type;

   typedef struct packed {
      logic [WORD_W-1:0]   uid;
      logic [WORD_W-1:0]   send;
      logic [WORD_W-1:0]   send_once;
   } entry_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

endpackage

[design/ryb_entry_mem.sv]
`timescale 1ns / 1ps

module ryb_entry_mem #(
   parameter int DEPTH = 64
) (
   input  logic                       clock,
   input  ryb_pkg::mem_ctl_type       mem_ctl,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  ryb_pkg::entry_type         wr_data,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output ryb_pkg::entry_type         rd_data
);

   ryb_pkg::entry_type entry_mem_ff [DEPTH];
   ryb_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         entry_mem_ff[wr_addr] <= wr_data;
      end
      if (mem_ctl.rd_en) begin
         rd_data_ff <= entry_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/ryb_seq.sv]
`timescale 1ns / 1ps

module ryb_seq #(
   parameter int DEPTH = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          lazy_enable,
   input  logic                          req_fire,
   input  ryb_pkg::req_word_type         req_word,
   input  logic                          slot_free,
   output logic                          busy,
   output logic                          out_load,
   output ryb_pkg::rsp_word_type         out_word,
   output ryb_pkg::mem_ctl_type          mem_ctl,
   output logic [$clog2(DEPTH)-1:0]      wr_addr,
   output ryb_pkg::entry_type            wr_data,
   output logic [$clog2(DEPTH)-1:0]      rd_addr,
   input  ryb_pkg::entry_type            rd_data,
   output logic [$clog2(DEPTH+1)-1:0]    entry_count
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   ryb_pkg::state_type                state_ff, state_in;
   ryb_pkg::req_word_type             cmd_ff, cmd_in;
   ryb_pkg::kind_type                 kind_ff, kind_in;
   logic [CNT_W-1:0]                  cnt_ff, cnt_in;
   logic [CNT_W-1:0]                  idx_ff, idx_in;
   logic [ryb_pkg::WORD_W-1:0]        node_ff, node_in;
   logic [ryb_pkg::WORD_W-1:0]        amount_ff, amount_in;
   logic [ryb_pkg::TICK_W-1:0]        tick_ff, tick_in;
   logic                              fire_ff, fire_in;
   logic                              append_ff, append_in;

   logic [CNT_W-1:0]                  idx_nxt;
   logic [CNT_W-1:0]                  cnt_plus;
   logic [CNT_W-1:0]                  tail_idx;
   logic                              walk_end;
   logic                              pending_other;
   logic                              hit;
   ryb_pkg::rsp_word_type             emit_word;

   assign idx_nxt       = idx_ff + CNT_W'(1);
   assign cnt_plus      = cnt_ff + CNT_W'(1);
   assign tail_idx      = cnt_ff - CNT_W'(1);
   assign walk_end      = (idx_nxt == cnt_ff);
   assign pending_other = (cnt_ff != '0) && (node_ff != req_word.node_id);
   assign hit           = (rd_data.uid == cmd_ff.port_uid);
   assign busy          = (state_ff != ryb_pkg::ST_IDLE);
   assign entry_count   = cnt_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ryb_pkg::ST_IDLE: begin
            if (req_fire) begin
               unique case (req_word.func)
                  ryb_pkg::FUNC_RECORD: begin
                     if (!lazy_enable) begin
                        state_in = ryb_pkg::ST_EMIT;
                     end else if (pending_other) begin
                        state_in = ryb_pkg::ST_FL_RD;
                     end else begin
                        state_in = ryb_pkg::ST_APPEND;
                     end
                  end
                  ryb_pkg::FUNC_REQUEST: begin
                     if ((cnt_ff != '0) && (node_ff == req_word.node_id)) begin
                        state_in = ryb_pkg::ST_SR_RD;
                     end else begin
                        state_in = ryb_pkg::ST_EMIT;
                     end
                  end
                  ryb_pkg::FUNC_TICK: begin
                     state_in = ryb_pkg::ST_EMIT;
                  end
                  ryb_pkg::FUNC_FLUSH: begin
                     if (cnt_ff != '0) begin
                        state_in = ryb_pkg::ST_FL_RD;
                     end
                  end
               endcase
            end
         end
         ryb_pkg::ST_APPEND: begin
            if ((cnt_plus == CNT_W'(DEPTH)) || (tick_ff != '0)) begin
               state_in = ryb_pkg::ST_FL_RD;
            end else begin
               state_in = ryb_pkg::ST_IDLE;
            end
         end
         ryb_pkg::ST_FL_RD: begin
            state_in = ryb_pkg::ST_FL_OUT;
         end
         ryb_pkg::ST_FL_OUT: begin
            if (slot_free) begin
               if (!walk_end) begin
                  state_in = ryb_pkg::ST_FL_RD;
               end else if (append_ff) begin
                  state_in = ryb_pkg::ST_APPEND;
               end else begin
                  state_in = ryb_pkg::ST_IDLE;
               end
            end
         end
         ryb_pkg::ST_SR_RD: begin
            state_in = ryb_pkg::ST_SR_CHK;
         end
         ryb_pkg::ST_SR_CHK: begin
            if (hit) begin
               if ((rd_data.send != '0) && (rd_data.send_once == '0)) begin
                  state_in = ryb_pkg::ST_TAIL_RD;
               end else begin
                  state_in = ryb_pkg::ST_EMIT;
               end
            end else if (walk_end) begin
               state_in = ryb_pkg::ST_EMIT;
            end else begin
               state_in = ryb_pkg::ST_SR_RD;
            end
         end
         ryb_pkg::ST_TAIL_RD: begin
            state_in = ryb_pkg::ST_TAIL_WR;
         end
         ryb_pkg::ST_TAIL_WR: begin
            state_in = ryb_pkg::ST_EMIT;
         end
         ryb_pkg::ST_EMIT: begin
            if (slot_free) begin
               state_in = ryb_pkg::ST_IDLE;
            end
         end
      endcase
   end

   // single-result word
   always_comb begin
      emit_word               = '0;
      emit_word.result_kind   = kind_ff;
      emit_word.last          = 1'b1;
      unique case (kind_ff)
         ryb_pkg::KIND_FLUSHED: begin
            emit_word.dest_node_out  = cmd_ff.node_id;
            emit_word.uid_out        = cmd_ff.port_uid;
            emit_word.send_count_out = cmd_ff.send_count;
            emit_word.send_once_out  = cmd_ff.send_once_count;
         end
         ryb_pkg::KIND_GRANT: begin
            emit_word.dest_node_out  = cmd_ff.node_id;
            emit_word.uid_out        = cmd_ff.port_uid;
            emit_word.send_count_out = amount_ff;
         end
         ryb_pkg::KIND_MISS: begin
            emit_word.dest_node_out  = cmd_ff.node_id;
            emit_word.uid_out        = cmd_ff.port_uid;
         end
         ryb_pkg::KIND_TICK: begin
            emit_word.timeout_fire   = fire_ff;
         end
      endcase
   end

   // outputs and datapath
   always_comb begin
      cmd_in    = cmd_ff;
      kind_in   = kind_ff;
      cnt_in    = cnt_ff;
      idx_in    = idx_ff;
      node_in   = node_ff;
      amount_in = amount_ff;
      tick_in   = tick_ff;
      fire_in   = fire_ff;
      append_in = append_ff;
      mem_ctl   = '0;
      rd_addr   = idx_ff[IDX_W-1:0];
      wr_addr   = idx_ff[IDX_W-1:0];
      wr_data   = rd_data;
      out_load  = 1'b0;
      out_word  = emit_word;
      unique case (state_ff)
         ryb_pkg::ST_IDLE: begin
            if (req_fire) begin
               cmd_in    = req_word;
               idx_in    = '0;
               append_in = 1'b0;
               unique case (req_word.func)
                  ryb_pkg::FUNC_RECORD: begin
                     kind_in   = ryb_pkg::KIND_FLUSHED;
                     append_in = lazy_enable && pending_other;
                  end
                  ryb_pkg::FUNC_REQUEST: begin
                     kind_in = ryb_pkg::KIND_MISS;
                  end
                  ryb_pkg::FUNC_TICK: begin
                     kind_in = ryb_pkg::KIND_TICK;
                     fire_in = (cnt_ff != '0) && (tick_ff != '0);
                     if ((cnt_ff != '0) && (tick_ff != ryb_pkg::TICK_MAX)) begin
                        tick_in = tick_ff + ryb_pkg::TICK_ONE;
                     end
                  end
                  ryb_pkg::FUNC_FLUSH: begin
                     kind_in = ryb_pkg::KIND_FLUSHED;
                  end
               endcase
            end
         end
         ryb_pkg::ST_APPEND: begin
            mem_ctl.wr_en     = 1'b1;
            wr_addr           = cnt_ff[IDX_W-1:0];
            wr_data.uid       = cmd_ff.port_uid;
            wr_data.send      = cmd_ff.send_count;
            wr_data.send_once = cmd_ff.send_once_count;
            cnt_in            = cnt_plus;
            node_in           = cmd_ff.node_id;
            append_in         = 1'b0;
            idx_in            = '0;
         end
         ryb_pkg::ST_FL_RD: begin
            mem_ctl.rd_en = 1'b1;
         end
         ryb_pkg::ST_FL_OUT: begin
            out_word                = '0;
            out_word.result_kind    = ryb_pkg::KIND_FLUSHED;
            out_word.dest_node_out  = node_ff;
            out_word.uid_out        = rd_data.uid;
            out_word.send_count_out = rd_data.send;
            out_word.send_once_out  = rd_data.send_once;
            out_word.last           = walk_end;
            if (slot_free) begin
               out_load = 1'b1;
               idx_in   = idx_nxt;
               if (walk_end) begin
                  cnt_in  = '0;
                  tick_in = '0;
                  idx_in  = '0;
               end
            end
         end
         ryb_pkg::ST_SR_RD: begin
            mem_ctl.rd_en = 1'b1;
         end
         ryb_pkg::ST_SR_CHK: begin
            if (hit) begin
               if (rd_data.send != '0) begin
                  kind_in   = ryb_pkg::KIND_GRANT;
                  amount_in = rd_data.send;
                  if (rd_data.send_once != '0) begin
                     mem_ctl.wr_en = 1'b1;
                     wr_data.send  = '0;
                  end
               end
            end else if (!walk_end) begin
               idx_in = idx_nxt;
            end
         end
         ryb_pkg::ST_TAIL_RD: begin
            mem_ctl.rd_en = 1'b1;
            rd_addr       = tail_idx[IDX_W-1:0];
         end
         ryb_pkg::ST_TAIL_WR: begin
            mem_ctl.wr_en = 1'b1;
            cnt_in        = tail_idx;
         end
         ryb_pkg::ST_EMIT: begin
            out_load = slot_free;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ryb_pkg::ST_IDLE;
         cnt_ff    <= '0;
         idx_ff    <= '0;
         node_ff   <= '0;
         tick_ff   <= '0;
         append_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         idx_ff    <= idx_in;
         node_ff   <= node_in;
         tick_ff   <= tick_in;
         append_ff <= append_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      kind_ff   <= kind_in;
      amount_ff <= amount_in;
      fire_ff   <= fire_in;
   end

endmodule

[design/reference_yield_batch_buffer.sv]
`timescale 1ns / 1ps

// Batching buffer for yielded port-right records bound for one node at a time.
// req_*: one command word per accept (record, send-count request, timer tick,
// flush). rsp_*: result words; last marks the final word of a command.
// csr_*: lazy_enable (reset value 1), written by the user only while the block
// is idle; the block itself does not enforce this. Entries live in one synchronous
// memory with one read port and one write port; every access to it goes through
// the sequencer, one entry per step. Steps from accept to the first result word:
//   record with lazy off, tick, request not on the held node: the result word only
//   record appended without a flush: one memory write, then the next command
//   flush: per buffered entry, one memory read and then one result word
//   request search: a read and a check per entry examined, plus the tail move
// req_stall stays high while a command is being worked on.
// A single output register holds the current result word; while rsp_stall is
// high the sequencer waits and the word is held. The next command is taken
// while the last result of the previous one is still waiting.
// Reset empties the buffer and clears the tick counter at once; memory
// contents are left as they are.
module reference_yield_batch_buffer #(
   parameter int BUFFER_DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  ryb_pkg::req_word_type    req_word,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output ryb_pkg::rsp_word_type    rsp_word,
   input  logic                     csr_wr_en,
   input  logic                     csr_wr_data
);

   localparam int IDX_W = $clog2(BUFFER_DEPTH);
   localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);

   logic                      lazy_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   ryb_pkg::rsp_word_type     rsp_word_ff, rsp_word_in;

   logic                      busy;
   logic                      req_fire;
   logic                      slot_free;
   logic                      out_load;
   ryb_pkg::rsp_word_type     out_word;
   ryb_pkg::mem_ctl_type      mem_ctl;
   logic [IDX_W-1:0]          wr_addr;
   logic [IDX_W-1:0]          rd_addr;
   ryb_pkg::entry_type        wr_data;
   ryb_pkg::entry_type        rd_data;
   logic [CNT_W-1:0]          entry_count;

   assign req_stall = busy;
   assign req_fire  = req_valid && !busy;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = out_word;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lazy_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            lazy_ff <= csr_wr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   ryb_seq #(
      .DEPTH (BUFFER_DEPTH)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .lazy_enable (lazy_ff),
      .req_fire    (req_fire),
      .req_word    (req_word),
      .slot_free   (slot_free),
      .busy        (busy),
      .out_load    (out_load),
      .out_word    (out_word),
      .mem_ctl     (mem_ctl),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data),
      .entry_count (entry_count)
   );

   ryb_entry_mem #(
      .DEPTH (BUFFER_DEPTH)
   ) u_mem (
      .clock   (clock),
      .mem_ctl (mem_ctl),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   a_load_only_when_free: assert property (@(posedge clock) disable iff (reset)
      out_load |-> slot_free)
      else $error("result loaded over a stalled word");

   a_idle_no_load: assert property (@(posedge clock) disable iff (reset)
      !busy |-> !out_load)
      else $error("result produced while idle");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      entry_count <= CNT_W'(BUFFER_DEPTH))
      else $error("entry count beyond buffer depth");

   a_mem_one_access: assert property (@(posedge clock) disable iff (reset)
      !(mem_ctl.wr_en && mem_ctl.rd_en))
      else $error("read and write issued together");

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;

   localparam int WORD_W = ryb_pkg::WORD_W;
   localparam int DEPTH = 64;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES = 16;
   localparam int TAIL_CYCLES = 400;
   localparam int PHASE_ITEMS = 12;
   localparam int IDLE_PCT = 59;
   localparam int BOTH_PCT = 11;
   localparam logic [WORD_W-1:0] ALL_ONES = '1;

   typedef enum int {EXTRA_NONE, EXTRA_FILL, EXTRA_STORM} extra_type;

   class rights_scoreboard;
      bit lazy_on;
      logic [WORD_W-1:0] held_node;
      int unsigned held_count;
      int unsigned tick_count;
      logic [WORD_W-1:0] held_uid [DEPTH];
      logic [WORD_W-1:0] held_send [DEPTH];
      logic [WORD_W-1:0] held_once [DEPTH];
      ryb_pkg::rsp_word_type due_words[$];
      int unsigned commands, words_checked, mismatches;
      int unsigned grants, misses, fired_ticks, flushes, full_flushes;
      bit saturated;

      function new();
         lazy_on = 1'b1;
         held_node = '0;
         held_count = 0;
         tick_count = 0;
         saturated = 1'b0;
      endfunction

      function void push_word(input ryb_pkg::kind_type kind,
                              input logic [WORD_W-1:0] node, uid, snd, once,
                              input logic fire);
         ryb_pkg::rsp_word_type w;
         w.result_kind = kind;
         w.dest_node_out = node;
         w.uid_out = uid;
         w.send_count_out = snd;
         w.send_once_out = once;
         w.timeout_fire = fire;
         w.last = 1'b0;
         due_words.push_back(w);
      endfunction

      // emit every held record toward the buffered node, oldest first
      function void empty_buffer();
         if (held_count == 0) return;
         flushes++;
         for (int i = 0; i < held_count; i++)
            push_word(ryb_pkg::KIND_FLUSHED, held_node, held_uid[i], held_send[i],
                      held_once[i], 1'b0);
         held_count = 0;
         tick_count = 0;
      endfunction

      function void note_command(input ryb_pkg::req_word_type w);
         int first;
         int hit;
         logic fire;
         logic [WORD_W-1:0] amount;
         ryb_pkg::rsp_word_type tail_word;
         first = due_words.size();
         commands++;
         case (w.func)
            ryb_pkg::FUNC_RECORD: begin
               if (!lazy_on) begin
                  push_word(ryb_pkg::KIND_FLUSHED, w.node_id, w.port_uid, w.send_count,
                            w.send_once_count, 1'b0);
               end else begin
                  if (held_count > 0 && held_node != w.node_id) empty_buffer();
                  held_node = w.node_id;
                  held_uid[held_count] = w.port_uid;
                  held_send[held_count] = w.send_count;
                  held_once[held_count] = w.send_once_count;
                  held_count++;
                  if (held_count == DEPTH) begin
                     full_flushes++;
                     empty_buffer();
                  end
                  if (tick_count > 0) empty_buffer();
               end
            end
            ryb_pkg::FUNC_REQUEST: begin
               hit = -1;
               if (held_count > 0 && held_node == w.node_id) begin
                  for (int i = 0; i < held_count && hit < 0; i++)
                     if (held_uid[i] == w.port_uid) hit = i;
               end
               if (hit >= 0 && held_send[hit] != 0) begin
                  amount = held_send[hit];
                  if (held_once[hit] == 0) begin
                     // tail entry moves into the freed slot
                     held_count--;
                     held_uid[hit] = held_uid[held_count];
                     held_send[hit] = held_send[held_count];
                     held_once[hit] = held_once[held_count];
                  end else begin
                     held_send[hit] = '0;
                  end
                  grants++;
                  push_word(ryb_pkg::KIND_GRANT, w.node_id, w.port_uid, amount, '0, 1'b0);
               end else begin
                  misses++;
                  push_word(ryb_pkg::KIND_MISS, w.node_id, w.port_uid, '0, '0, 1'b0);
               end
            end
            ryb_pkg::FUNC_TICK: begin
               fire = 1'b0;
               if (held_count != 0) begin
                  fire = (tick_count > 0);
                  if (tick_count < ryb_pkg::TICK_MAX) tick_count++;
                  else saturated = 1'b1;
               end
               if (fire) fired_ticks++;
               push_word(ryb_pkg::KIND_TICK, '0, '0, '0, '0, fire);
            end
            ryb_pkg::FUNC_FLUSH: begin
               empty_buffer();
            end
         endcase
         if (due_words.size() > first) begin
            tail_word = due_words.pop_back();
            tail_word.last = 1'b1;
            due_words.push_back(tail_word);
         end
      endfunction

      function void compare_field(input string name, input logic [WORD_W-1:0] want, got);
         if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_word(input ryb_pkg::rsp_word_type got);
         ryb_pkg::rsp_word_type want;
         if (due_words.size() == 0) begin
            $error("result word with nothing expected: kind %0d uid %h",
                   got.result_kind, got.uid_out);
            mismatches++;
            return;
         end
         want = due_words.pop_front();
         words_checked++;
         compare_field("result_kind", want.result_kind, got.result_kind);
         compare_field("dest_node_out", want.dest_node_out, got.dest_node_out);
         compare_field("uid_out", want.uid_out, got.uid_out);
         compare_field("send_count_out", want.send_count_out, got.send_count_out);
         compare_field("send_once_out", want.send_once_out, got.send_once_out);
         compare_field("timeout_fire", want.timeout_fire, got.timeout_fire);
         compare_field("last", want.last, got.last);
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   ryb_pkg::req_word_type req_word;
   logic rsp_valid;
   logic rsp_stall;
   ryb_pkg::rsp_word_type rsp_word;
   logic csr_wr_en;
   logic csr_wr_data;

   int send_gap_pct;
   int stall_pct;
   int quiet_cycles;
   logic [WORD_W-1:0] node_pool [4];
   rights_scoreboard sb;

   reference_yield_batch_buffer #(
      .BUFFER_DEPTH(DEPTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word(rsp_word),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_word(rsp_word);
   end

   // counts cycles in which neither side moves a word
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: errors");
            $finish;
         end
      end
   end

   function automatic logic [WORD_W-1:0] pick_count();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return ALL_ONES;
         2: return 1;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [WORD_W-1:0] pick_node();
      if ($urandom_range(0, 5) == 0) return $urandom();
      return node_pool[$urandom_range(0, 3)];
   endfunction

   task automatic send_word(input ryb_pkg::func_type func,
                            input logic [WORD_W-1:0] node, uid, snd, once);
      ryb_pkg::req_word_type w;
      w.func = func;
      w.node_id = node;
      w.port_uid = uid;
      w.send_count = snd;
      w.send_once_count = once;
      @(negedge clock);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_command(w);
   endtask

   task automatic write_lazy(input logic value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      sb.lazy_on = value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic drain(input int settle);
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.due_words.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // records for one node with requests, ticks and stray words mixed in
   task automatic run_batch();
      logic [WORD_W-1:0] node;
      logic [WORD_W-1:0] uid;
      logic [WORD_W-1:0] uids[$];
      int steps;
      int roll;
      node = pick_node();
      steps = $urandom_range(2, 14);
      for (int i = 0; i < steps; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < 55) begin
            if (uids.size() > 0 && $urandom_range(0, 4) == 0) begin
               uid = uids[$urandom_range(0, uids.size() - 1)];
            end else begin
               uid = $urandom();
               uids.push_back(uid);
            end
            send_word(ryb_pkg::FUNC_RECORD, node, uid, pick_count(), pick_count());
         end else if (roll < 80) begin
            uid = (uids.size() > 0 && $urandom_range(0, 4) != 0) ?
                  uids[$urandom_range(0, uids.size() - 1)] : $urandom();
            send_word(ryb_pkg::FUNC_REQUEST,
                      ($urandom_range(0, 6) == 0) ? pick_node() : node, uid,
                      $urandom(), $urandom());
         end else if (roll < 90) begin
            send_word(ryb_pkg::FUNC_TICK, $urandom(), $urandom(), $urandom(), $urandom());
         end else if (roll < 95) begin
            send_word(ryb_pkg::FUNC_RECORD, pick_node(), $urandom(), pick_count(),
                      pick_count());
         end else begin
            send_word(ryb_pkg::FUNC_FLUSH, $urandom(), $urandom(), $urandom(), $urandom());
         end
      end
      case ($urandom_range(0, 3))
         0: begin
            send_word(ryb_pkg::FUNC_FLUSH, $urandom(), $urandom(), $urandom(), $urandom());
         end
         1: begin
            send_word(ryb_pkg::FUNC_TICK, $urandom(), $urandom(), $urandom(), $urandom());
            send_word(ryb_pkg::FUNC_RECORD, node, $urandom(), pick_count(), pick_count());
         end
         2: begin
            send_word(ryb_pkg::FUNC_RECORD, pick_node(), $urandom(), pick_count(),
                      pick_count());
         end
         default: begin
         end
      endcase
   endtask

   task automatic run_phase(input logic lazy, input int gap, input int stall,
                            input extra_type extra);
      logic [WORD_W-1:0] node;
      int start;
      int mark;
      drain(SETTLE_CYCLES);
      send_gap_pct = gap;
      stall_pct = stall;
      node_pool[2] = $urandom();
      node_pool[3] = $urandom();
      write_lazy(lazy);
      start = sb.commands;
      node = pick_node();
      if (extra == EXTRA_FILL) begin
         // keep one node until the buffer runs full
         mark = sb.full_flushes;
         send_word(ryb_pkg::FUNC_FLUSH, node, '0, '0, '0);
         while (sb.full_flushes == mark) begin
            if (sb.held_count > 0 && $urandom_range(0, 9) == 0)
               send_word(ryb_pkg::FUNC_REQUEST, node,
                         sb.held_uid[$urandom_range(0, sb.held_count - 1)],
                         $urandom(), $urandom());
            else
               send_word(ryb_pkg::FUNC_RECORD, node, $urandom(), pick_count(), pick_count());
         end
      end else if (extra == EXTRA_STORM) begin
         // enough ticks on a pending entry to pin the tick counter
         send_word(ryb_pkg::FUNC_FLUSH, node, '0, '0, '0);
         send_word(ryb_pkg::FUNC_RECORD, node, $urandom(), pick_count(), pick_count());
         send_word(ryb_pkg::FUNC_RECORD, node, $urandom(), pick_count(), pick_count());
         repeat (int'(ryb_pkg::TICK_MAX) + 3)
            send_word(ryb_pkg::FUNC_TICK, $urandom(), $urandom(), $urandom(), $urandom());
         send_word(ryb_pkg::FUNC_RECORD, node, $urandom(), pick_count(), pick_count());
      end
      while (sb.commands - start < PHASE_ITEMS) run_batch();
   endtask

   initial begin
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      rsp_stall = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = 1'b0;
      send_gap_pct = 0;
      stall_pct = 0;
      quiet_cycles = 0;
      node_pool[0] = '0;
      node_pool[1] = ALL_ONES;
      node_pool[2] = $urandom();
      node_pool[3] = $urandom();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      write_lazy(1'b1);

      // empty buffer cases
      send_word(ryb_pkg::FUNC_TICK, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
      send_word(ryb_pkg::FUNC_FLUSH, '0, '0, '0, '0);
      send_word(ryb_pkg::FUNC_REQUEST, '0, '0, '0, '0);
      // zero send count is a miss
      send_word(ryb_pkg::FUNC_RECORD, '0, '0, '0, '0);
      send_word(ryb_pkg::FUNC_REQUEST, '0, '0, ALL_ONES, ALL_ONES);
      send_word(ryb_pkg::FUNC_RECORD, '0, ALL_ONES, ALL_ONES, ALL_ONES);
      send_word(ryb_pkg::FUNC_RECORD, '0, 32'd5, 32'd7, '0);
      send_word(ryb_pkg::FUNC_RECORD, '0, 32'd9, 32'd3, 32'd2);
      // grant with entry kept, then nothing left to grant
      send_word(ryb_pkg::FUNC_REQUEST, '0, ALL_ONES, '0, '0);
      send_word(ryb_pkg::FUNC_REQUEST, '0, ALL_ONES, '0, '0);
      // grant with entry removed, a miss on another node, then a grant with entry kept
      send_word(ryb_pkg::FUNC_REQUEST, '0, 32'd5, '0, '0);
      send_word(ryb_pkg::FUNC_REQUEST, ALL_ONES, 32'd9, '0, '0);
      send_word(ryb_pkg::FUNC_REQUEST, '0, 32'd9, '0, '0);
      // destination change, then tick driven flush
      send_word(ryb_pkg::FUNC_RECORD, ALL_ONES, 32'hA5A5A5A5, 32'h5A5A5A5A, 32'hA5A5A5A5);
      send_word(ryb_pkg::FUNC_TICK, '0, '0, '0, '0);
      send_word(ryb_pkg::FUNC_TICK, '0, '0, '0, '0);
      send_word(ryb_pkg::FUNC_RECORD, ALL_ONES, 32'h0F0F0F0F, 32'd1, 32'd1);
      // duplicate ids: first match decides
      send_word(ryb_pkg::FUNC_RECORD, 32'h12345678, 32'd1, 32'd1, 32'd1);
      send_word(ryb_pkg::FUNC_RECORD, 32'h12345678, 32'd1, 32'd2, '0);
      send_word(ryb_pkg::FUNC_REQUEST, 32'h12345678, 32'd1, '0, '0);
      send_word(ryb_pkg::FUNC_REQUEST, 32'h12345678, 32'd1, '0, '0);
      send_word(ryb_pkg::FUNC_FLUSH, '0, '0, '0, '0);
      send_word(ryb_pkg::FUNC_RECORD, 32'h5A5A5A5A, 32'h3C3C3C3C, 32'd11, '0);
      // pass-through mode with an entry still held
      drain(SETTLE_CYCLES);
      write_lazy(1'b0);
      send_word(ryb_pkg::FUNC_RECORD, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
      send_word(ryb_pkg::FUNC_TICK, '0, '0, '0, '0);
      send_word(ryb_pkg::FUNC_TICK, '0, '0, '0, '0);
      send_word(ryb_pkg::FUNC_FLUSH, '0, '0, '0, '0);

      run_phase(1'b1, 0, 0, EXTRA_NONE);
      run_phase(1'b1, IDLE_PCT, 0, EXTRA_NONE);
      run_phase(1'b0, 0, IDLE_PCT, EXTRA_NONE);
      run_phase(1'b1, 0, IDLE_PCT, EXTRA_STORM);
      run_phase(1'b1, BOTH_PCT, BOTH_PCT, EXTRA_FILL);
      drain(TAIL_CYCLES);

      $display("covered %0d commands, %0d result words: %0d grants, %0d misses, %0d fired ticks",
               sb.commands, sb.words_checked, sb.grants, sb.misses, sb.fired_ticks);
      $display("%0d buffer flushes, %0d on a full buffer; tick counter pinned at max: %0d",
               sb.flushes, sb.full_flushes, sb.saturated);
      if (sb.mismatches == 0 && sb.due_words.size() == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
